>>> hdl/fbfl_pkg.sv
`default_nettype none

package fbfl_pkg;

   // Pool geometry: block indexes are 8 bits wide and links carry one more bit for null
   localparam int unsigned MAX_BLOCKS  = 256;
   localparam int unsigned BLOCK_BYTES = 1024;
   localparam int unsigned IDX_W       = $clog2(MAX_BLOCKS);
   localparam int unsigned LINK_W      = IDX_W + 1;
   localparam int unsigned SIZE_W      = 16;

   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_POOL   = 3'd1,
      ST_TOO_LARGE = 3'd2,
      ST_EMPTY     = 3'd3,
      ST_BAD_INDEX = 3'd4
   } status_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [LINK_W-1:0] data;
   } link_wr_type;

   typedef struct packed {
      logic              en;
      logic [LINK_W-1:0] data;
   } link_byp_type;

endpackage

`default_nettype wire

>>> hdl/fbfl_if.sv
`default_nettype none

interface fbfl_req_if import fbfl_pkg::*; ();
   logic                valid;
   logic                ready;
   op_type              operation;
   logic [SIZE_W-1:0]   request_size;
   logic [IDX_W-1:0]    freed_index;

   modport source (output valid, output operation, output request_size,
                   output freed_index, input ready);
   modport sink   (input valid, input operation, input request_size,
                   input freed_index, output ready);
endinterface

interface fbfl_rsp_if import fbfl_pkg::*; ();
   logic                valid;
   logic                ready;
   status_type          status;
   logic [IDX_W-1:0]    granted_index;

   modport source (output valid, output status, output granted_index, input ready);
   modport sink   (input valid, input status, input granted_index, output ready);
endinterface

`default_nettype wire

>>> hdl/fbfl_link_store.sv
`default_nettype none

module fbfl_link_store import fbfl_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              clear,
   input  wire link_wr_type       wr,
   input  wire link_byp_type      byp,
   input  wire logic [IDX_W-1:0]  rd_addr,
   input  wire logic [LINK_W-1:0] pool,
   output logic      [LINK_W-1:0] rd_link
);

   logic [LINK_W-1:0]     mem [MAX_BLOCKS];
   logic [MAX_BLOCKS-1:0] written_ff;
   logic [LINK_W-1:0]     rd_data_ff;
   logic                  rd_written_ff;
   logic [LINK_W-1:0]     dflt_ff;
   logic [LINK_W-1:0]     dflt_in;
   logic [LINK_W-1:0]     succ;
   logic                  byp_ff;
   logic [LINK_W-1:0]     byp_data_ff;

   // An entry never written since the last rebuild reads as its place in the initial chain
   assign succ    = LINK_W'(rd_addr) + LINK_W'(1);
   assign dflt_in = (succ < pool) ? succ : NULL_LINK;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff    <= mem[rd_addr];
      rd_written_ff <= written_ff[rd_addr];
      dflt_ff       <= dflt_in;
      byp_data_ff   <= byp.data;
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         written_ff <= '0;
      end else if (wr.en) begin
         written_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= byp.en;
      end
   end

   // The bypass stands in for the registered array read right after a write, while that read still shows stale data
   assign rd_link = byp_ff        ? byp_data_ff :
                    rd_written_ff ? rd_data_ff  : dflt_ff;

endmodule

`default_nettype wire

>>> hdl/fixed_block_free_list_allocator_unit.sv
`default_nettype none

// Free-list allocator for a pool of equal blocks. Each beat on req either allocates
// (pops the head of the free chain) or frees (pushes freed_index onto the head), unless
// it fails with an error status, and gives exactly one rsp beat. The unit takes one
// beat per cycle while rsp is ready: a request is held in the input register until the
// output register is free, and its result then goes into the output register; the link
// of the current head is always ready from a registered read of the link array, or from
// a one-cycle bypass right after a free or a pool write. Writing csr_wr_data sets the
// pool size (saturated to 256) and rebuilds the chain through per-block written flags,
// so there is no clearing pass. Write the pool size only while no beat is in flight.
module fixed_block_free_list_allocator_unit import fbfl_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [LINK_W-1:0] csr_wr_data,
   fbfl_req_if.sink               req,
   fbfl_rsp_if.source             rsp
);

   logic                in_vld_ff,  in_vld_in;
   op_type              in_op_ff;
   logic [SIZE_W-1:0]   in_size_ff;
   logic [IDX_W-1:0]    in_idx_ff;

   logic                out_vld_ff, out_vld_in;
   status_type          out_status_ff, out_status_in;
   logic [IDX_W-1:0]    out_grant_ff,  out_grant_in;

   logic [LINK_W-1:0]   head_ff, head_in;
   logic [LINK_W-1:0]   pool_ff, pool_in;
   logic [LINK_W-1:0]   pool_sat;
   logic [LINK_W-1:0]   head_link;

   logic                fire;
   link_wr_type         link_wr;
   link_byp_type        link_byp;

   assign fire      = in_vld_ff && (!out_vld_ff || rsp.ready);
   assign req.ready = !in_vld_ff || fire;

   assign in_vld_in  = (req.valid && req.ready) || (in_vld_ff && !fire);
   assign out_vld_in = fire || (out_vld_ff && !rsp.ready);

   assign pool_sat = (csr_wr_data > LINK_W'(MAX_BLOCKS)) ? LINK_W'(MAX_BLOCKS) : csr_wr_data;

   always_comb begin
      head_in       = head_ff;
      pool_in       = pool_ff;
      out_status_in = ST_OK;
      out_grant_in  = '0;
      link_wr       = '{en: 1'b0, addr: in_idx_ff, data: head_ff};
      link_byp      = '{en: 1'b0, data: head_ff};
      if (csr_wr_en) begin
         pool_in       = pool_sat;
         head_in       = (pool_sat == '0) ? NULL_LINK : '0;
         link_byp.en   = 1'b1;
         link_byp.data = (pool_sat > LINK_W'(1)) ? LINK_W'(1) : NULL_LINK;
      end else if (fire) begin
         if (pool_ff == '0) begin
            out_status_in = ST_NO_POOL;
         end else if (in_op_ff == OP_ALLOC) begin
            if (in_size_ff > SIZE_W'(BLOCK_BYTES)) begin
               out_status_in = ST_TOO_LARGE;
            end else if (head_ff >= pool_ff) begin
               out_status_in = ST_EMPTY;
            end else begin
               out_grant_in = head_ff[IDX_W-1:0];
               head_in      = head_link;
            end
         end else begin
            if (LINK_W'(in_idx_ff) >= pool_ff) begin
               out_status_in = ST_BAD_INDEX;
            end else begin
               // push: the freed block points at the old head
               link_wr.en  = 1'b1;
               link_byp.en = 1'b1;
               head_in     = LINK_W'(in_idx_ff);
            end
         end
      end
   end

   fbfl_link_store u_links (
      .clock   (clock),
      .reset   (reset),
      .clear   (csr_wr_en),
      .wr      (link_wr),
      .byp     (link_byp),
      .rd_addr (head_in[IDX_W-1:0]),
      .pool    (pool_ff),
      .rd_link (head_link)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         head_ff    <= NULL_LINK;
         pool_ff    <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         head_ff    <= head_in;
         pool_ff    <= pool_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_op_ff   <= req.operation;
         in_size_ff <= req.request_size;
         in_idx_ff  <= req.freed_index;
      end
      if (fire) begin
         out_status_ff <= out_status_in;
         out_grant_ff  <= out_grant_in;
      end
   end

   assign rsp.valid         = out_vld_ff;
   assign rsp.status        = out_status_ff;
   assign rsp.granted_index = out_grant_ff;

   // The head is either null or a block inside the pool
   a_head_in_pool: assert property (@(posedge clock) disable iff (reset)
      (head_ff == NULL_LINK) || (head_ff < pool_ff))
      else $error("free head outside the pool");

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      pool_ff <= LINK_W'(MAX_BLOCKS))
      else $error("pool size above the maximum");

   a_grant_only_ok: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && (out_status_ff != ST_OK)) |-> (out_grant_ff == '0))
      else $error("granted index set on a failed request");

   a_fire_lands: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_vld_ff)
      else $error("processed beat lost before the output register");

endmodule

`default_nettype wire
